@@ sv/cyclic_error_trapping_decoder_assert.svh @@
// assertion macros used by the decoder checker
// depends on nothing; included by the checker file
`ifndef CYCLIC_ERROR_TRAPPING_DECODER_ASSERT_SVH
`define CYCLIC_ERROR_TRAPPING_DECODER_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define CETD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked from the same edge or the next edge
`define CETD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ sv/cetd_pkg.sv @@
// shared widths, types and word rotation helpers of the error trapping decoder
// no dependencies
package cetd_pkg;

	localparam int WordW   = 12;
	localparam int DataW   = 6;
	localparam int NumCols = 6;
	localparam int MaxRot  = 11;
	localparam int RotW    = $clog2(MaxRot);
	localparam int CfgIdxW = $clog2(NumCols);

	typedef logic [WordW-1:0] word_t;
	typedef logic [DataW-1:0] synd_t;
	typedef logic [RotW-1:0]  rot_t;
	typedef word_t [NumCols-1:0] col_arr_t;
	typedef synd_t [MaxRot-1:0]  synd_arr_t;

	// outcome of the trapping search for one request
	typedef struct packed {
		logic  found;
		rot_t  rot;
		synd_t synd;
	} sel_t;

	// reset value of parity-check column p: a single bit at parity position p
	function automatic word_t col_reset(int unsigned p);
		logic [2*WordW-1:0] t;
		t = (2*WordW)'(1) << (DataW + p);
		return t[WordW-1:0];
	endfunction

	// rotate toward the lower index by a constant count
	function automatic word_t rot_dn(word_t w, int unsigned n);
		logic [2*WordW-1:0] t;
		t = {w, w} >> n;
		return t[WordW-1:0];
	endfunction

	// rotate toward the higher index by a run-time count
	function automatic word_t rot_up(word_t w, rot_t n);
		logic [2*WordW-1:0] t;
		t = {w, w} << n;
		return t[2*WordW-1:WordW];
	endfunction

endpackage

@@ sv/cetd_in_if.sv @@
// input channel of the error trapping decoder: one received word per request
// depends on cetd_pkg
interface cetd_in_if import cetd_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t received_word;

	modport source (output valid, output received_word, input ready);
	modport sink (input valid, input received_word, output ready);
endinterface

@@ sv/cetd_out_if.sv @@
// output channel of the error trapping decoder: decoded word and status
// depends on cetd_pkg
interface cetd_out_if import cetd_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t corrected_word;
	synd_t data_bits;
	logic  error_fixed;
	logic  decode_status;

	modport source (output valid, output corrected_word, output data_bits,
		output error_fixed, output decode_status, input ready);
	modport sink (input valid, input corrected_word, input data_bits,
		input error_fixed, input decode_status, output ready);
endinterface

@@ sv/cetd_synd.sv @@
// stage 1: syndromes of the received word at every trial rotation
// depends on cetd_pkg
module cetd_synd import cetd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      adv,
	input  logic      in_valid,
	input  word_t     in_word,
	input  col_arr_t  cols,
	output logic      vld_s1,
	output word_t     word_s1,
	output synd_arr_t synd_s1
);

	synd_arr_t synd;

	// one parity tree per rotation and matrix column
	always_comb begin
		for (int r = 0; r < MaxRot; r++) begin
			for (int p = 0; p < DataW; p++) begin
				synd[r][p] = ^(rot_dn(in_word, r) & cols[p]);
			end
		end
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (adv) begin
			word_s1 <= in_word;
			synd_s1 <= synd;
		end
	end

endmodule

@@ sv/cetd_sel.sv @@
// stage 2: picks the first rotation whose syndrome weight is at most one
// depends on cetd_pkg
module cetd_sel import cetd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      adv,
	input  logic      vld_s1,
	input  word_t     word_s1,
	input  synd_arr_t synd_s1,
	output logic      vld_s2,
	output word_t     word_s2,
	output sel_t      sel_s2
);

	sel_t sel;

	// priority search, lowest rotation wins
	always_comb begin
		sel = '0;
		for (int r = MaxRot - 1; r >= 0; r--) begin
			if ((synd_s1[r] & (synd_s1[r] - synd_t'(1))) == '0) begin
				sel.found = 1'b1;
				sel.rot   = rot_t'(r);
				sel.synd  = synd_s1[r];
			end
		end
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (adv) begin
			word_s2 <= word_s1;
			sel_s2  <= sel;
		end
	end

endmodule

@@ sv/cetd_fix.sv @@
// stage 3: flips the trapped parity bit at the original position, output register
// depends on cetd_pkg
module cetd_fix import cetd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  logic  vld_s2,
	input  word_t word_s2,
	input  sel_t  sel_s2,
	output logic  vld_s3,
	output word_t word_s3,
	output logic  fixed_s3,
	output logic  status_s3
);

	logic  one;
	word_t flip;

	// a single-bit syndrome corrects; the pattern is rotated back before the xor
	assign one  = sel_s2.found && (sel_s2.synd != '0);
	assign flip = rot_up({sel_s2.synd, {(WordW - DataW){1'b0}}}, sel_s2.rot);

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (adv) begin
			word_s3   <= one ? (word_s2 ^ flip) : word_s2;
			fixed_s3  <= one;
			status_s3 <= !sel_s2.found;
		end
	end

endmodule

@@ sv/cyclic_error_trapping_decoder.sv @@
// top level of the single-error trapping decoder for a (12,6) cyclic code
// depends on cetd_pkg, cetd_in_if, cetd_out_if, cetd_synd, cetd_sel, cetd_fix

// Decodes one received 12-bit word per clock cycle: stage 1 forms the syndromes
// for all eleven trial rotations in parallel, stage 2 picks the first rotation
// with syndrome weight zero or one, stage 3 applies the correction and holds the
// result in the output register. The whole pipeline advances together and halts
// only while a finished result waits at the output, so throughput is one
// request per cycle as long as the sink takes results. The user must write the
// six parity-check columns through the configuration port only while the block
// is idle; the block does not enforce this. Indexes past five are ignored.
module cyclic_error_trapping_decoder import cetd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_idx,
	input  word_t               cfg_data,
	cetd_in_if.sink             in_ch,
	cetd_out_if.source          out_ch
);

	col_arr_t  col_q;
	logic      adv;
	logic      vld_s1;
	word_t     word_s1;
	synd_arr_t synd_s1;
	logic      vld_s2;
	word_t     word_s2;
	sel_t      sel_s2;
	logic      vld_s3;
	word_t     word_s3;
	logic      fixed_s3;
	logic      status_s3;

	// parity-check column registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NumCols; p++) begin
				col_q[p] <= col_reset(p);
			end
		end else if (cfg_we) begin
			for (int p = 0; p < NumCols; p++) begin
				if (cfg_idx == CfgIdxW'(p)) begin
					col_q[p] <= cfg_data;
				end
			end
		end
	end

	// pipeline moves whenever the output register is free or being emptied
	assign adv         = !vld_s3 || out_ch.ready;
	assign in_ch.ready = adv;

	cetd_synd u_synd (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (in_ch.valid),
		.in_word  (in_ch.received_word),
		.cols     (col_q),
		.vld_s1   (vld_s1),
		.word_s1  (word_s1),
		.synd_s1  (synd_s1)
	);

	cetd_sel u_sel (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.vld_s1  (vld_s1),
		.word_s1 (word_s1),
		.synd_s1 (synd_s1),
		.vld_s2  (vld_s2),
		.word_s2 (word_s2),
		.sel_s2  (sel_s2)
	);

	cetd_fix u_fix (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.vld_s2    (vld_s2),
		.word_s2   (word_s2),
		.sel_s2    (sel_s2),
		.vld_s3    (vld_s3),
		.word_s3   (word_s3),
		.fixed_s3  (fixed_s3),
		.status_s3 (status_s3)
	);

	// result channel
	assign out_ch.valid          = vld_s3;
	assign out_ch.corrected_word = word_s3;
	assign out_ch.data_bits      = word_s3[DataW-1:0];
	assign out_ch.error_fixed    = fixed_s3;
	assign out_ch.decode_status  = status_s3;

endmodule

@@ sv/cetd_chk.sv @@
// port-level checker for the error trapping decoder, bound to the top level
// depends on cetd_pkg and cyclic_error_trapping_decoder_assert.svh
`include "cyclic_error_trapping_decoder_assert.svh"

module cetd_chk import cetd_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  in_ready,
	input logic  out_valid,
	input logic  out_ready,
	input word_t corrected_word,
	input synd_t data_bits,
	input logic  error_fixed,
	input logic  decode_status
);

	// data bits mirror the low half of the decoded word
	`CETD_ASSERT_IMP(a_data_bits, clk, arst_n, out_valid, data_bits == corrected_word[DataW-1:0], "data_bits differ from corrected_word")

	// an uncorrectable word is never reported as repaired
	`CETD_ASSERT_IMP(a_status_fixed, clk, arst_n, out_valid && decode_status, !error_fixed, "uncorrectable word flagged as fixed")

	// input side stalls exactly when a result is held at the output
	`CETD_ASSERT(a_ready, clk, arst_n, in_ready == (!out_valid || out_ready), "input ready does not follow output stall")

	// a held result stays put
	`CETD_ASSERT_IMP(a_hold, clk, arst_n, out_valid && !out_ready, ##1 (out_valid && $stable(corrected_word)), "stalled result changed")

endmodule

bind cyclic_error_trapping_decoder cetd_chk u_cetd_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_ready       (in_ch.ready),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.corrected_word (out_ch.corrected_word),
	.data_bits      (out_ch.data_bits),
	.error_fixed    (out_ch.error_fixed),
	.decode_status  (out_ch.decode_status)
);

@@ bench/tb_cyclic_error_trapping_decoder.sv @@
// self-checking bench for the (12,6) single-error trapping decoder: a directed table, then
// random words under several parity-check matrices, checked against table values or a model
// depends on cetd_pkg, cetd_in_if, cetd_out_if and cyclic_error_trapping_decoder
module tb_cyclic_error_trapping_decoder import cetd_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic DEC_OK            = 1'b0;
	localparam logic DEC_UNCORRECTABLE = 1'b1;
	localparam int   PHASES            = 8;
	localparam int   WORDS_PER_PHASE   = 140;
	localparam int   HOLD_AFTER_WORDS  = 350;
	localparam int   HOLD_CYCLES       = 80;

	typedef enum logic [CfgIdxW-1:0] {
		REG_CHECK_COL_0 = 3'd0,
		REG_CHECK_COL_1 = 3'd1,
		REG_CHECK_COL_2 = 3'd2,
		REG_CHECK_COL_3 = 3'd3,
		REG_CHECK_COL_4 = 3'd4,
		REG_CHECK_COL_5 = 3'd5,
		REG_SPARE_6     = 3'd6,
		REG_SPARE_7     = 3'd7
	} reg_idx_e;

	typedef enum {CFG_RESET, CFG_UNIFORM, CFG_SPARSE, CFG_ONES, CFG_MIXED, CFG_ZERO} cfg_mode_e;
	typedef enum {ROW_WORD, ROW_CFG} row_kind_e;

	typedef struct packed {
		word_t             word;
		logic [DataW-1:0]  data;
		logic              fixed;
		logic              status;
	} dec_result_t;

	typedef struct {
		row_kind_e   kind;
		reg_idx_e    idx;
		word_t       value;
		bit          known;
		dec_result_t want;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [CfgIdxW-1:0] cfg_idx;
	word_t              cfg_data;

	cetd_in_if  in_ch();
	cetd_out_if out_ch();

	// shadow of the parity-check columns
	word_t       check_cols [NumCols];
	dec_result_t decoded_q [$];
	stim_row_t   stim_rows [$];
	int          words_accepted;
	int          mismatches;
	bit          src_steady;
	bit          use_typed;
	dec_result_t typed_want;
	dec_result_t got_result;
	dec_result_t want_result;

	cyclic_error_trapping_decoder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	// syndrome bit p is the parity of the word masked by column p
	function automatic logic [DataW-1:0] check_syndrome(word_t w);
		logic [DataW-1:0] s;
		for (int p = 0; p < NumCols; p++) begin
			s[p] = ^(w & check_cols[p]);
		end
		return s;
	endfunction

	// rotate down until the syndrome weight is at most one, fix parity, rotate back
	function automatic dec_result_t trap_decode(word_t rx);
		word_t            w;
		logic [DataW-1:0] s;
		int               rot;
		bit               done;
		dec_result_t      r;
		w = rx;
		rot = 0;
		done = 0;
		r.fixed = 1'b0;
		r.status = DEC_OK;
		while (!done) begin
			s = check_syndrome(w);
			if ($countones(s) == 1) begin
				w = w ^ {s, {DataW{1'b0}}};
				r.fixed = 1'b1;
				done = 1;
			end else if (s == '0) begin
				done = 1;
			end else begin
				w = {w[0], w[WordW-1:1]};
				rot++;
				if (rot >= MaxRot) begin
					r.status = DEC_UNCORRECTABLE;
					done = 1;
				end
			end
		end
		if (r.status == DEC_UNCORRECTABLE) begin
			w = rx;
		end else begin
			repeat (rot) w = {w[WordW-2:0], w[WordW-1]};
		end
		r.word = w;
		r.data = w[DataW-1:0];
		return r;
	endfunction

	// mostly short idle stretches, now and then a long one
	function automatic int idle_len();
		return ($urandom_range(99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 30);
	endfunction

	function automatic word_t col_value(cfg_mode_e mode, int p);
		word_t v;
		case (mode)
			CFG_RESET:   v = word_t'(12'h040 << p);
			CFG_UNIFORM: v = word_t'($urandom);
			CFG_SPARSE:  v = word_t'(1) << $urandom_range(WordW - 1);
			CFG_ONES:    v = '1;
			CFG_MIXED: begin
				v = word_t'(1) << $urandom_range(WordW - 1);
				v[$urandom_range(WordW - 1)] = 1'b1;
			end
			default:     v = '0;
		endcase
		return v;
	endfunction

	// uniform words, sparse words, and data with one or two parity bits set
	function automatic word_t rand_word();
		word_t w;
		int    r;
		r = $urandom_range(99);
		w = '0;
		if (r < 45) begin
			w = word_t'($urandom);
		end else if (r < 80) begin
			repeat ($urandom_range(1, 3)) w[$urandom_range(WordW - 1)] = 1'b1;
		end else begin
			w[DataW-1:0] = DataW'($urandom);
			w[DataW + $urandom_range(NumCols - 1)] = 1'b1;
			if ($urandom_range(1)) w[DataW + $urandom_range(NumCols - 1)] = 1'b1;
		end
		return w;
	endfunction

	function automatic void add_word(word_t w);
		stim_row_t row;
		row.kind = ROW_WORD;
		row.idx = REG_CHECK_COL_0;
		row.value = w;
		row.known = 0;
		row.want = '0;
		stim_rows.push_back(row);
	endfunction

	function automatic void add_known(word_t w, word_t fw, logic fixed, logic status);
		stim_row_t row;
		row.kind = ROW_WORD;
		row.idx = REG_CHECK_COL_0;
		row.value = w;
		row.known = 1;
		row.want = {fw, fw[DataW-1:0], fixed, status};
		stim_rows.push_back(row);
	endfunction

	function automatic void add_cfg(reg_idx_e idx, word_t val);
		stim_row_t row;
		row.kind = ROW_CFG;
		row.idx = idx;
		row.value = val;
		row.known = 0;
		row.want = '0;
		stim_rows.push_back(row);
	endfunction

	task automatic write_reg(reg_idx_e idx, word_t val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		if (idx < NumCols) check_cols[idx] = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// offer one request after a random gap and hold it until taken
	task automatic push_word(word_t w, bit typed, dec_result_t want);
		int gap;
		gap = (src_steady || $urandom_range(99) < 65) ? 0 : idle_len();
		if (gap > 0) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
			in_ch.received_word <= word_t'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.received_word <= w;
		use_typed = typed;
		typed_want = want;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// stop offering and wait for every outstanding result
	task automatic wait_drained();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (decoded_q.size() != 0) @(negedge clk);
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#5ms;
		$display("tb_cyclic_error_trapping_decoder failed");
		$finish;
	end

	// record the expected decode of every accepted request
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) begin
			decoded_q.push_back(use_typed ? typed_want : trap_decode(in_ch.received_word));
			words_accepted++;
		end
	end

	// compare every accepted result with the oldest expected decode
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got_result = {out_ch.corrected_word, out_ch.data_bits, out_ch.error_fixed,
				out_ch.decode_status};
			if (decoded_q.size() == 0) begin
				$display("%0t: unexpected result word %h data %h fixed %b status %b", $time,
					got_result.word, got_result.data, got_result.fixed, got_result.status);
				mismatches++;
			end else begin
				want_result = decoded_q.pop_front();
				if (got_result !== want_result) begin
					$display({"%0t: expected word %h data %h fixed %b status %b, ",
						"got word %h data %h fixed %b status %b"},
						$time, want_result.word, want_result.data, want_result.fixed,
						want_result.status, got_result.word, got_result.data, got_result.fixed,
						got_result.status);
					mismatches++;
				end
			end
		end
	end

	// result sink: random stalls, steady stretches and one long hold-off
	initial begin
		int hold;
		int stretch;
		bit steady;
		bit long_hold_done;
		hold = 0;
		stretch = 0;
		steady = 0;
		long_hold_done = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				out_ch.ready <= 1'b0;
				hold--;
			end else if (!long_hold_done && words_accepted >= HOLD_AFTER_WORDS) begin
				long_hold_done = 1;
				out_ch.ready <= 1'b0;
				hold = HOLD_CYCLES - 1;
			end else begin
				if (stretch == 0) begin
					stretch = $urandom_range(20, 120);
					steady = ($urandom_range(3) == 0);
				end
				stretch--;
				if (steady || $urandom_range(99) < 75) begin
					out_ch.ready <= 1'b1;
				end else begin
					out_ch.ready <= 1'b0;
					hold = idle_len() - 1;
				end
			end
		end
	end

	// reset, directed table, random phases, verdict
	initial begin
		cfg_mode_e mode;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.received_word = '0;
		out_ch.ready = 1'b0;
		arst_n = 1'b0;
		words_accepted = 0;
		mismatches = 0;
		src_steady = 0;
		use_typed = 0;
		typed_want = '0;
		for (int p = 0; p < NumCols; p++) check_cols[p] = word_t'(12'h040 << p);

		// reset matrix: syndrome equals the parity bits
		add_known(12'h000, 12'h000, 1'b0, DEC_OK);
		add_known(12'h03F, 12'h03F, 1'b0, DEC_OK);
		add_known(12'h001, 12'h001, 1'b0, DEC_OK);
		add_known(12'h040, 12'h000, 1'b1, DEC_OK);
		add_known(12'h800, 12'h000, 1'b1, DEC_OK);
		add_known(12'h041, 12'h001, 1'b1, DEC_OK);
		add_known(12'hFFF, 12'hFFF, 1'b0, DEC_UNCORRECTABLE);
		add_word(12'hFC0);
		add_word(12'h0C0);
		add_word(12'hA00);
		add_word(12'h555);
		add_word(12'hAAA);
		// two columns on bit 0 only: a word with bit 0 set reaches zero syndrome once a clear bit rotates into bit 0
		add_cfg(REG_CHECK_COL_0, 12'h001);
		add_cfg(REG_CHECK_COL_1, 12'h001);
		for (int p = 2; p < NumCols; p++) add_cfg(reg_idx_e'(p), 12'h000);
		add_word(12'h001);
		add_word(12'h002);
		// writes past the last column are ignored
		add_cfg(REG_SPARE_6, 12'hFFF);
		add_cfg(REG_SPARE_7, 12'h000);
		add_word(12'h001);
		// all-ones columns: every syndrome bit is the word parity
		for (int p = 0; p < NumCols; p++) add_cfg(reg_idx_e'(p), 12'hFFF);
		add_known(12'h001, 12'h001, 1'b0, DEC_UNCORRECTABLE);
		add_known(12'h003, 12'h003, 1'b0, DEC_OK);
		// all-zero columns: nothing is ever corrected
		for (int p = 0; p < NumCols; p++) add_cfg(reg_idx_e'(p), 12'h000);
		add_known(12'hFFF, 12'hFFF, 1'b0, DEC_OK);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (stim_rows[i]) begin
			if (stim_rows[i].kind == ROW_CFG) begin
				wait_drained();
				write_reg(stim_rows[i].idx, stim_rows[i].value);
			end else begin
				push_word(stim_rows[i].value, stim_rows[i].known, stim_rows[i].want);
			end
		end

		// random words, one parity-check matrix per phase
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			mode = cfg_mode_e'(ph % 6);
			for (int p = 0; p < NumCols; p++) write_reg(reg_idx_e'(p), col_value(mode, p));
			write_reg($urandom_range(1) ? REG_SPARE_6 : REG_SPARE_7, word_t'($urandom));
			src_steady = ($urandom_range(3) == 0);
			repeat (WORDS_PER_PHASE) push_word(rand_word(), 1'b0, '0);
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && decoded_q.size() == 0) begin
			$display("tb_cyclic_error_trapping_decoder passed");
		end else begin
			$display("tb_cyclic_error_trapping_decoder failed");
		end
		$finish;
	end

endmodule
